FILE: hdl/mpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mpq_pkg;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_EXTRACT = 2'd1,
    OP_PEEK    = 2'd2,
    OP_SEARCH  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_WAIT,
    S_DECIDE,
    S_SHIFT,
    S_SHIFT_WAIT,
    S_FIN
  } state_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               found;
    status_t            status;
    logic [3:0]         occupancy;
  } out_t;

  // control from the sequencer to the scan unit
  typedef struct packed {
    logic clear;
    logic step;
    logic first;
  } scan_ctl_t;

endpackage

`default_nettype wire

FILE: hdl/mpq_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module mpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/mpq_scan.sv
`timescale 1ns / 1ps
`default_nettype none

module mpq_scan
  import mpq_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int IDX_W      = 3
) (
  input  wire logic                         clk,
  input  wire scan_ctl_t                    ctl,
  input  wire logic signed [DATA_WIDTH-1:0] data,
  input  wire logic        [IDX_W-1:0]      idx,
  input  wire logic signed [DATA_WIDTH-1:0] key,
  output logic signed      [DATA_WIDTH-1:0] best_value,
  output logic             [IDX_W-1:0]      best_idx,
  output logic                              found
);

  logic greater;
  logic equal;

  // one magnitude comparator and one equality comparator, one entry per step
  assign greater = data > best_value;
  assign equal   = data == key;

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      found <= 1'b0;
    end else if (ctl.step) begin
      // strict greater keeps the lowest index on ties
      if (ctl.first || greater) begin
        best_value <= data;
        best_idx   <= idx;
      end
      if (equal) begin
        found <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/max_priority_queue_array_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Insert, and any request on an empty store, go straight to the finish state; else
//   the N entries held are scanned, one RAM read per cycle, and extract then shifts
//   the entries above the maximum down one place. One transaction at a time;
//   the next is taken once the result is in the output register.
// Reset (rst, synchronous): store empty, no result pending; entry RAM is not cleared.
`default_nettype none

module max_priority_queue_array_core
  import mpq_pkg::*;
#(
  parameter int CAPACITY   = 8,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  state_t state, state_next;
  logic [CNT_W-1:0] count, count_next;
  op_t              op_r;
  logic signed [DATA_WIDTH-1:0] key, key_in;
  logic [IDX_W-1:0] rd_idx, rd_idx_next;
  logic             pend_valid;
  logic [IDX_W-1:0] pend_idx;
  logic             load_out;
  out_t             out_next;

  logic                  rd_en, wr_en;
  logic [IDX_W-1:0]      rd_addr, wr_addr;
  logic [DATA_WIDTH-1:0] rd_data, wr_data;

  scan_ctl_t                    scan_ctl;
  logic signed [DATA_WIDTH-1:0] best_value;
  logic [IDX_W-1:0]             best_idx;
  logic                         found;

  logic [IDX_W-1:0] last_idx;
  logic             full;
  logic signed [31:0] best_32;
  logic [CNT_W+3:0] occ_ext;

  assign last_idx = IDX_W'(count - CNT_W'(1));
  assign full     = count == CNT_W'(CAPACITY);

  generate
    if (DATA_WIDTH > 32) begin : g_wide
      assign key_in  = {{(DATA_WIDTH-32){in_data.value[31]}}, in_data.value};
      assign best_32 = best_value[31:0];
    end else if (DATA_WIDTH == 32) begin : g_same
      assign key_in  = in_data.value;
      assign best_32 = best_value;
    end else begin : g_narrow
      assign key_in  = in_data.value[DATA_WIDTH-1:0];
      assign best_32 = {{(32-DATA_WIDTH){best_value[DATA_WIDTH-1]}}, best_value};
    end
  endgenerate

  mpq_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  mpq_scan #(
    .DATA_WIDTH(DATA_WIDTH),
    .IDX_W     (IDX_W)
  ) u_scan (
    .clk       (clk),
    .ctl       (scan_ctl),
    .data      (rd_data),
    .idx       (pend_idx),
    .key       (key),
    .best_value(best_value),
    .best_idx  (best_idx),
    .found     (found)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      pend_valid <= rd_en;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx   <= rd_idx_next;
    pend_idx <= rd_addr;
    if (in_valid && !in_stall) begin
      op_r <= in_data.op;
      key  <= key_in;
    end
    if (load_out) begin
      out_data <= out_next;
    end
  end

  // result fields from the finished transaction
  always_comb begin
    logic [CNT_W-1:0] cnt_after;
    cnt_after             = count;
    out_next.result_value = '0;
    out_next.found        = 1'b0;
    out_next.status       = STAT_OK;
    case (op_r)
      OP_INSERT: begin
        if (full) begin
          out_next.status = STAT_FULL;
        end else begin
          cnt_after = count + CNT_W'(1);
        end
      end
      OP_EXTRACT, OP_PEEK: begin
        if (count == '0) begin
          out_next.status = STAT_EMPTY;
        end else begin
          out_next.result_value = best_32;
          if (op_r == OP_EXTRACT) begin
            cnt_after = count - CNT_W'(1);
          end
        end
      end
      OP_SEARCH: begin
        out_next.found = found;
      end
      default: begin
        out_next.status = STAT_OK;
      end
    endcase
    occ_ext            = {4'b0000, cnt_after};
    out_next.occupancy = occ_ext[3:0];
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    rd_idx_next    = rd_idx;
    rd_en          = 1'b0;
    rd_addr        = rd_idx;
    wr_en          = 1'b0;
    wr_addr        = pend_idx - IDX_W'(1);
    wr_data        = rd_data;
    in_stall       = 1'b1;
    load_out       = 1'b0;
    scan_ctl.clear = 1'b0;
    scan_ctl.step  = pend_valid && (state == S_SCAN || state == S_SCAN_WAIT);
    scan_ctl.first = pend_idx == '0;

    // shifted entry lands one place below where it was read
    if (pend_valid && (state == S_SHIFT || state == S_SHIFT_WAIT)) begin
      wr_en = 1'b1;
    end

    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          scan_ctl.clear = 1'b1;
          rd_idx_next    = '0;
          if (in_data.op == OP_INSERT || count == '0) begin
            state_next = S_FIN;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        rd_en = 1'b1;
        if (rd_idx == last_idx) begin
          state_next = S_SCAN_WAIT;
        end else begin
          rd_idx_next = rd_idx + IDX_W'(1);
        end
      end
      S_SCAN_WAIT: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (op_r == OP_EXTRACT && best_idx != last_idx) begin
          rd_idx_next = best_idx + IDX_W'(1);
          state_next  = S_SHIFT;
        end else begin
          state_next = S_FIN;
        end
      end
      S_SHIFT: begin
        rd_en = 1'b1;
        if (rd_idx == last_idx) begin
          state_next = S_SHIFT_WAIT;
        end else begin
          rd_idx_next = rd_idx + IDX_W'(1);
        end
      end
      S_SHIFT_WAIT: begin
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
          case (op_r)
            OP_INSERT: begin
              if (!full) begin
                wr_en      = 1'b1;
                wr_addr    = IDX_W'(count);
                wr_data    = key;
                count_next = count + CNT_W'(1);
              end
            end
            OP_EXTRACT: begin
              if (count != '0) begin
                count_next = count - CNT_W'(1);
              end
            end
            default: begin
              count_next = count;
            end
          endcase
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("held count above capacity");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("new transaction taken while one is in progress");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && state == S_IDLE))
    else $error("entry write while idle");

  a_load_needs_room: assert property (@(posedge clk) disable iff (rst)
    load_out |-> (!out_valid || !out_stall))
    else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

FILE: verif/mpq_checker.sv
`timescale 1ns / 1ps
module mpq_checker
  import mpq_pkg::*;
#(
  parameter int CAPACITY = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_stall,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_stall,
  input  out_t out_data,
  output int   errors,
  output int   pending,
  output int   n_checked,
  output int   n_full,
  output int   n_empty,
  output int   n_hits
);

  // shadow copy of the store
  logic signed [31:0] held_vals [CAPACITY];
  int                 held_n;
  out_t               reply_q [$];

  initial begin
    errors    = 0;
    pending   = 0;
    n_checked = 0;
    n_full    = 0;
    n_empty   = 0;
    n_hits    = 0;
    held_n    = 0;
  end

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mpq_checker: response %0d %s: got %0h, want %0h",
             n_checked, field, got, want);
    errors++;
  endtask

  function automatic out_t serve_request(input in_t req);
    out_t r;
    int   best;
    r        = '0;
    r.status = STAT_OK;
    case (req.op)
      OP_INSERT: begin
        if (held_n >= CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          held_vals[held_n] = req.value;
          held_n++;
        end
      end
      OP_EXTRACT, OP_PEEK: begin
        if (held_n == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          // strict compare keeps the lowest index among equal maxima
          best = 0;
          for (int i = 1; i < held_n; i++)
            if (held_vals[i] > held_vals[best]) best = i;
          r.result_value = held_vals[best];
          if (req.op == OP_EXTRACT) begin
            for (int i = best; i < held_n - 1; i++) held_vals[i] = held_vals[i + 1];
            held_n--;
          end
        end
      end
      default: begin
        for (int i = 0; i < held_n; i++)
          if (held_vals[i] == req.value) r.found = 1'b1;
      end
    endcase
    r.occupancy = held_n[3:0];
    return r;
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      held_n = 0;
      reply_q.delete();
    end else begin
      // results always trail their requests, so check before push
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (reply_q.size() == 0) begin
          report_mismatch("transaction with no request outstanding", out_data[31:0], '0);
        end else begin
          want = reply_q.pop_front();
          n_checked++;
          if (out_data.result_value !== want.result_value)
            report_mismatch("result_value", out_data.result_value, want.result_value);
          if (out_data.found !== want.found)
            report_mismatch("found", 32'(out_data.found), 32'(want.found));
          if (out_data.status !== want.status)
            report_mismatch("status", 32'(out_data.status), 32'(want.status));
          if (out_data.occupancy !== want.occupancy)
            report_mismatch("occupancy", 32'(out_data.occupancy), 32'(want.occupancy));
          if (want.status == STAT_FULL) n_full++;
          if (want.status == STAT_EMPTY) n_empty++;
          if (want.found) n_hits++;
        end
      end
      if (in_valid === 1'b1 && in_stall === 1'b0) reply_q.push_back(serve_request(in_data));
    end
    pending = reply_q.size();
  end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import mpq_pkg::*;

  localparam int CAPACITY     = 8;
  localparam int RANDOM_ITEMS = 1700;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 20;
  localparam int CYCLE_LIMIT  = 600000;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  int errors, pending, n_checked, n_full, n_empty, n_hits;
  int holds_asked = 0;
  int holds_done  = 0;
  int cycle_cnt   = 0;
  int n_sent      = 0;

  // recently inserted values, to make searches hit
  logic signed [31:0] recent [16];
  int                 recent_wr = 0;

  always #10 clk = ~clk;

  max_priority_queue_array_core #(
    .CAPACITY  (CAPACITY),
    .DATA_WIDTH(32)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  mpq_checker #(.CAPACITY(CAPACITY)) u_check (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .errors   (errors),
    .pending  (pending),
    .n_checked(n_checked),
    .n_full   (n_full),
    .n_empty  (n_empty),
    .n_hits   (n_hits)
  );

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_top: cycle limit reached, %0d results outstanding", pending);
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_req(input op_t op, input logic signed [31:0] v);
    in_data  = '{op: op, value: v};
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    @(negedge clk);
    n_sent++;
    if (op == OP_INSERT) begin
      recent[recent_wr] = v;
      recent_wr         = (recent_wr + 1) % 16;
    end
  endtask

  task automatic idle(input int n);
    if (n > 0) begin
      in_valid = 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2, 3, 4: return int'($urandom_range(0, 8)) - 4;
      5:       return recent[$urandom_range(0, 15)];
      default: return $urandom;
    endcase
  endfunction

  // receiver: changing stall patterns, plus long hold-offs on request
  initial begin
    int rx_mode;
    int mode_left;
    int phase;
    rx_mode   = 0;
    mode_left = 0;
    phase     = 0;
    forever begin
      @(negedge clk);
      if (holds_done != holds_asked) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        holds_done++;
        out_stall = 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        phase++;
        case (rx_mode)
          0:       out_stall = 1'b0;
          1:       out_stall = ($urandom_range(0, 1) == 1);
          2:       out_stall = ($urandom_range(0, 9) < 8);
          default: out_stall = (phase % 5 < 2);
        endcase
      end
    end
  end

  initial begin
    int   ins_weight;
    int   burst_left;
    op_t  op;
    logic signed [31:0] v;
    foreach (recent[i]) recent[i] = '0;
    repeat (11) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // empty store corners
    send_req(OP_PEEK, 32'sh0);
    send_req(OP_EXTRACT, 32'shffffffff);
    send_req(OP_SEARCH, 32'sh0);
    // fill with extremes and a duplicated maximum
    send_req(OP_INSERT, 32'sh7fffffff);
    send_req(OP_INSERT, 32'sh80000000);
    send_req(OP_INSERT, 32'sh0);
    send_req(OP_INSERT, -32'sd1);
    send_req(OP_INSERT, 32'sd1);
    send_req(OP_INSERT, 32'sh7fffffff);
    send_req(OP_INSERT, 32'sd5);
    send_req(OP_INSERT, 32'sh55555555);
    send_req(OP_INSERT, 32'shaaaaaaaa);   // store full
    send_req(OP_SEARCH, 32'sh80000000);
    send_req(OP_SEARCH, 32'sd2);
    send_req(OP_PEEK, 32'sh12345678);
    repeat (CAPACITY) send_req(OP_EXTRACT, 32'sh0);
    send_req(OP_EXTRACT, 32'sh0);
    send_req(OP_PEEK, 32'sh0);
    idle(3);

    burst_left = 0;
    ins_weight = 50;
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 100 == 0) begin
        case ($urandom_range(0, 2))
          0:       ins_weight = 15;
          1:       ins_weight = 50;
          default: ins_weight = 85;
        endcase
      end
      // long receiver hold while requests keep coming
      if (k == 500 || k == 1300) holds_asked++;
      if (k == 900 || k == 1500) begin
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        @(negedge clk);
      end
      if (burst_left == 0) begin
        idle($urandom_range(0, 6));
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      if ($urandom_range(0, 99) < ins_weight) begin
        op = OP_INSERT;
      end else begin
        case ($urandom_range(0, 3))
          0, 1:    op = OP_EXTRACT;
          2:       op = OP_PEEK;
          default: op = OP_SEARCH;
        endcase
      end
      if (op == OP_SEARCH && $urandom_range(0, 1) == 1) v = recent[$urandom_range(0, 15)];
      else if (op == OP_INSERT || op == OP_SEARCH) v = pick_value();
      else v = $urandom;
      send_req(op, v);
    end

    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("tb_top: %0d requests sent, %0d responses checked, %0d mismatches",
             n_sent, n_checked, errors);
    $display("tb_top: %0d full inserts, %0d empty reads, %0d search hits, %0d long holds",
             n_full, n_empty, n_hits, holds_done);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
